@@ rtl/pts_pkg.sv @@
// Shared codes for the priority task scheduler: action and status encodings,
// plus the fixed width of the sequence stamp counter. No dependencies.
package pts_pkg;

    localparam int STAMP_BITS = 32;

    localparam logic [2:0] ACT_CREATE_READY = 3'd0;
    localparam logic [2:0] ACT_CREATE_WAIT  = 3'd1;
    localparam logic [2:0] ACT_DELETE       = 3'd2;
    localparam logic [2:0] ACT_WAIT         = 3'd3;
    localparam logic [2:0] ACT_TRIGGER      = 3'd4;
    localparam logic [2:0] ACT_SUSPEND      = 3'd5;
    localparam logic [2:0] ACT_SCHEDULE     = 3'd6;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_DUP      = 3'd1;
    localparam logic [2:0] STS_FULL     = 3'd2;
    localparam logic [2:0] STS_NOTFOUND = 3'd3;
    localparam logic [2:0] STS_RUNNING  = 3'd4;
    localparam logic [2:0] STS_MISMATCH = 3'd5;
    localparam logic [2:0] STS_BADACT   = 3'd6;
    localparam logic [2:0] STS_STAMP    = 3'd7;

endpackage

@@ rtl/priority_task_scheduler.sv @@
// Priority task scheduler top level: task table memory, scan sequencer, result register.
// Depends on pts_pkg for action and status codes.
//
// Every action walks the task table through its single read port, one slot per cycle, then
// decides and writes back at most one entry. A trigger that releases tasks makes a second
// walk over the table. The finish state also waits while an earlier result is held by
// out_stall. A new transaction is taken while the previous result still waits on the
// output register.
// Occupancy is kept in per-slot flip-flops, so no clearing pass follows reset.
// Equal-priority ordering is held as a 64-bit key per slot: tasks released together by a
// trigger share the current stamp in the upper half and keep their waiting order in the
// lower half.
module priority_task_scheduler #(
    parameter int MAX_TASKS  = 16,
    parameter int ID_BITS    = 8,
    parameter int PRI_BITS   = 8,
    parameter int EVENT_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [EVENT_BITS-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            action,
    input  logic [ID_BITS-1:0]    task_id,
    input  logic [PRI_BITS-1:0]   priority_req,
    input  logic [EVENT_BITS-1:0] evt_code,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            status,
    output logic                  running_valid,
    output logic [7:0]            running_id,
    output logic [7:0]            running_priority,
    output logic                  preempted,
    output logic [4:0]            ready_count,
    output logic [4:0]            waiting_count,
    output logic [4:0]            moved_count
);
    import pts_pkg::*;

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int SB = STAMP_BITS;
    localparam int KW = 2 * SB;
    localparam int EW = ID_BITS + PRI_BITS + EVENT_BITS + 1 + KW;
    localparam int K_LO = 0;
    localparam int W_LO = KW;
    localparam int E_LO = KW + 1;
    localparam int P_LO = E_LO + EVENT_BITS;
    localparam int T_LO = P_LO + PRI_BITS;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_TRIG   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    // task table memory
    logic [EW-1:0] mem [MAX_TASKS];
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [EW-1:0] mem_wd;
    logic [IW-1:0] mem_ra;
    logic [EW-1:0] rd_data_reg;

    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  rdv_reg, rdv_next;
    logic [IW-1:0]         rdi_reg, rdi_next;
    logic [2:0]            act_reg, act_next;
    logic [ID_BITS-1:0]    id_reg, id_next;
    logic [PRI_BITS-1:0]   pri_reg, pri_next;
    logic [EVENT_BITS-1:0] ev_reg, ev_next;
    logic [EVENT_BITS-1:0] def_ev_reg, def_ev_next;

    logic                  fnd_reg, fnd_next;
    logic [IW-1:0]         fnd_idx_reg, fnd_idx_next;
    logic                  fnd_wait_reg, fnd_wait_next;
    logic [ID_BITS-1:0]    fnd_task_reg, fnd_task_next;
    logic [PRI_BITS-1:0]   fnd_pri_reg, fnd_pri_next;
    logic                  free_reg, free_next;
    logic [IW-1:0]         free_idx_reg, free_idx_next;
    logic                  best_reg, best_next;
    logic [IW-1:0]         best_idx_reg, best_idx_next;
    logic [ID_BITS-1:0]    best_task_reg, best_task_next;
    logic [PRI_BITS-1:0]   best_pri_reg, best_pri_next;
    logic [EVENT_BITS-1:0] best_ev_reg, best_ev_next;
    logic [KW-1:0]         best_key_reg, best_key_next;
    logic [CW-1:0]         match_reg, match_next;

    logic [MAX_TASKS-1:0]  used_reg, used_next;
    logic [SB-1:0]         stamp_reg, stamp_next;
    logic [SB-1:0]         base_reg, base_next;
    logic [CW-1:0]         rdy_reg, rdy_next;
    logic [CW-1:0]         wt_reg, wt_next;
    logic                  run_v_reg, run_v_next;
    logic [ID_BITS-1:0]    run_task_reg, run_task_next;
    logic [PRI_BITS-1:0]   run_pri_reg, run_pri_next;
    logic [EVENT_BITS-1:0] run_ev_reg, run_ev_next;

    logic [2:0]            sts_reg, sts_next;
    logic                  pre_reg, pre_next;
    logic [CW-1:0]         moved_reg, moved_next;

    logic                  ov_reg, ov_next;
    logic [2:0]            o_sts_reg, o_sts_next;
    logic                  o_rv_reg, o_rv_next;
    logic [7:0]            o_id_reg, o_id_next;
    logic [7:0]            o_pri_reg, o_pri_next;
    logic                  o_pre_reg, o_pre_next;
    logic [4:0]            o_rdy_reg, o_rdy_next;
    logic [4:0]            o_wt_reg, o_wt_next;
    logic [4:0]            o_mv_reg, o_mv_next;

    // read data fields
    logic [ID_BITS-1:0]    rd_task;
    logic [PRI_BITS-1:0]   rd_pri;
    logic [EVENT_BITS-1:0] rd_ev;
    logic                  rd_wait;
    logic [KW-1:0]         rd_key;
    logic                  rd_used;

    logic [SB:0]           fit1_sum, fitn_sum;
    logic                  fit1, fitn;
    logic                  run_is_id;
    logic [KW-1:0]         fresh_key;
    logic [ID_BITS+7:0]    id_ext;
    logic [PRI_BITS+7:0]   pri_ext;
    logic [CW+4:0]         rdy_ext, wt_ext, mv_ext;

    assign rd_task = rd_data_reg[T_LO +: ID_BITS];
    assign rd_pri  = rd_data_reg[P_LO +: PRI_BITS];
    assign rd_ev   = rd_data_reg[E_LO +: EVENT_BITS];
    assign rd_wait = rd_data_reg[W_LO];
    assign rd_key  = rd_data_reg[K_LO +: KW];
    assign rd_used = used_reg[rdi_reg];

    assign fit1_sum  = {1'b0, stamp_reg} + (SB+1)'(1);
    assign fitn_sum  = {1'b0, stamp_reg} + (SB+1)'(match_reg);
    assign fit1      = !fit1_sum[SB];
    assign fitn      = !fitn_sum[SB];
    assign run_is_id = run_v_reg && (run_task_reg == id_reg);
    assign fresh_key = {stamp_reg, {SB{1'b0}}};

    assign mem_ra = cnt_reg[IW-1:0];

    // memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    // sequencer and action logic
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rdv_next       = 1'b0;
        rdi_next       = rdi_reg;
        act_next       = act_reg;
        id_next        = id_reg;
        pri_next       = pri_reg;
        ev_next        = ev_reg;
        def_ev_next    = cfg_write ? cfg_data : def_ev_reg;
        fnd_next       = fnd_reg;
        fnd_idx_next   = fnd_idx_reg;
        fnd_wait_next  = fnd_wait_reg;
        fnd_task_next  = fnd_task_reg;
        fnd_pri_next   = fnd_pri_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        best_task_next = best_task_reg;
        best_pri_next  = best_pri_reg;
        best_ev_next   = best_ev_reg;
        best_key_next  = best_key_reg;
        match_next     = match_reg;
        used_next      = used_reg;
        stamp_next     = stamp_reg;
        base_next      = base_reg;
        rdy_next       = rdy_reg;
        wt_next        = wt_reg;
        run_v_next     = run_v_reg;
        run_task_next  = run_task_reg;
        run_pri_next   = run_pri_reg;
        run_ev_next    = run_ev_reg;
        sts_next       = sts_reg;
        pre_next       = pre_reg;
        moved_next     = moved_reg;
        mem_we         = 1'b0;
        mem_wa         = rdi_reg;
        mem_wd         = rd_data_reg;
        in_stall       = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = action;
                    id_next    = task_id;
                    pri_next   = priority_req;
                    ev_next    = evt_code;
                    cnt_next   = '0;
                    fnd_next   = 1'b0;
                    free_next  = 1'b0;
                    best_next  = 1'b0;
                    match_next = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // issue reads, one slot per cycle
                if (cnt_reg != CW'(MAX_TASKS))
                begin
                    rdv_next = 1'b1;
                    rdi_next = cnt_reg[IW-1:0];
                    cnt_next = cnt_reg + CW'(1);
                end
                else if (!rdv_reg)
                begin
                    state_next = S_EXEC;
                end
                // examine the slot read last cycle
                if (rdv_reg)
                begin
                    if (!rd_used)
                    begin
                        if (!free_reg)
                        begin
                            free_next     = 1'b1;
                            free_idx_next = rdi_reg;
                        end
                    end
                    else
                    begin
                        if (rd_task == id_reg)
                        begin
                            fnd_next      = 1'b1;
                            fnd_idx_next  = rdi_reg;
                            fnd_wait_next = rd_wait;
                            fnd_task_next = rd_task;
                            fnd_pri_next  = rd_pri;
                        end
                        if (rd_wait && rd_ev == ev_reg)
                        begin
                            match_next = match_reg + CW'(1);
                        end
                        if (!rd_wait && (!best_reg || rd_pri < best_pri_reg ||
                            (rd_pri == best_pri_reg && rd_key < best_key_reg)))
                        begin
                            best_next      = 1'b1;
                            best_idx_next  = rdi_reg;
                            best_task_next = rd_task;
                            best_pri_next  = rd_pri;
                            best_ev_next   = rd_ev;
                            best_key_next  = rd_key;
                        end
                    end
                end
            end
            S_EXEC:
            begin
                sts_next   = STS_OK;
                pre_next   = 1'b0;
                moved_next = '0;
                state_next = S_FINISH;
                case (act_reg)
                    ACT_CREATE_READY, ACT_CREATE_WAIT:
                    begin
                        if (fnd_reg || run_is_id)
                            sts_next = STS_DUP;
                        else if (!free_reg)
                            sts_next = STS_FULL;
                        else if (!fit1)
                            sts_next = STS_STAMP;
                        else
                        begin
                            mem_we = 1'b1;
                            mem_wa = free_idx_reg;
                            if (act_reg == ACT_CREATE_WAIT)
                            begin
                                mem_wd  = {id_reg, pri_reg, ev_reg, 1'b1, fresh_key};
                                wt_next = wt_reg + CW'(1);
                            end
                            else
                            begin
                                mem_wd   = {id_reg, pri_reg, def_ev_reg, 1'b0, fresh_key};
                                rdy_next = rdy_reg + CW'(1);
                            end
                            used_next[free_idx_reg] = 1'b1;
                            stamp_next = stamp_reg + SB'(1);
                        end
                    end
                    ACT_DELETE:
                    begin
                        if (fnd_reg)
                        begin
                            used_next[fnd_idx_reg] = 1'b0;
                            if (fnd_wait_reg)
                                wt_next = wt_reg - CW'(1);
                            else
                                rdy_next = rdy_reg - CW'(1);
                        end
                        else
                            sts_next = run_is_id ? STS_RUNNING : STS_NOTFOUND;
                    end
                    ACT_WAIT:
                    begin
                        if (!fnd_reg || fnd_wait_reg)
                            sts_next = run_is_id ? STS_RUNNING : STS_NOTFOUND;
                        else if (!fit1)
                            sts_next = STS_STAMP;
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_wa     = fnd_idx_reg;
                            mem_wd     = {fnd_task_reg, fnd_pri_reg, ev_reg, 1'b1, fresh_key};
                            stamp_next = stamp_reg + SB'(1);
                            rdy_next   = rdy_reg - CW'(1);
                            wt_next    = wt_reg + CW'(1);
                        end
                    end
                    ACT_TRIGGER:
                    begin
                        if (match_reg != '0)
                        begin
                            if (!fitn)
                                sts_next = STS_STAMP;
                            else
                            begin
                                // second walk releases the matching slots
                                base_next  = stamp_reg;
                                stamp_next = fitn_sum[SB-1:0];
                                rdy_next   = rdy_reg + match_reg;
                                wt_next    = wt_reg - match_reg;
                                moved_next = match_reg;
                                cnt_next   = '0;
                                state_next = S_TRIG;
                            end
                        end
                    end
                    ACT_SUSPEND:
                    begin
                        if (!run_v_reg)
                            sts_next = STS_NOTFOUND;
                        else if (run_ev_reg != ev_reg)
                            sts_next = STS_MISMATCH;
                        else if (!free_reg)
                            sts_next = STS_FULL;
                        else if (!fit1)
                            sts_next = STS_STAMP;
                        else
                        begin
                            mem_we = 1'b1;
                            mem_wa = free_idx_reg;
                            mem_wd = {run_task_reg, run_pri_reg, run_ev_reg, 1'b1, fresh_key};
                            used_next[free_idx_reg] = 1'b1;
                            stamp_next = stamp_reg + SB'(1);
                            wt_next    = wt_reg + CW'(1);
                            run_v_next = 1'b0;
                        end
                    end
                    ACT_SCHEDULE:
                    begin
                        if (best_reg && !run_v_reg)
                        begin
                            run_v_next    = 1'b1;
                            run_task_next = best_task_reg;
                            run_pri_next  = best_pri_reg;
                            run_ev_next   = best_ev_reg;
                            used_next[best_idx_reg] = 1'b0;
                            rdy_next = rdy_reg - CW'(1);
                        end
                        else if (best_reg && best_pri_reg < run_pri_reg)
                        begin
                            if (!fit1)
                                sts_next = STS_STAMP;
                            else
                            begin
                                mem_we = 1'b1;
                                mem_wa = best_idx_reg;
                                mem_wd = {run_task_reg, run_pri_reg, run_ev_reg, 1'b0,
                                          fresh_key};
                                stamp_next    = stamp_reg + SB'(1);
                                run_task_next = best_task_reg;
                                run_pri_next  = best_pri_reg;
                                run_ev_next   = best_ev_reg;
                                pre_next      = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        sts_next = STS_BADACT;
                    end
                endcase
            end
            S_TRIG:
            begin
                if (cnt_reg != CW'(MAX_TASKS))
                begin
                    rdv_next = 1'b1;
                    rdi_next = cnt_reg[IW-1:0];
                    cnt_next = cnt_reg + CW'(1);
                end
                else if (!rdv_reg)
                begin
                    state_next = S_FINISH;
                end
                // released tasks share the base stamp and keep their waiting order
                if (rdv_reg && rd_used && rd_wait && rd_ev == ev_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = rdi_reg;
                    mem_wd = {rd_task, rd_pri, rd_ev, 1'b0, base_reg, rd_key[KW-1:SB]};
                end
            end
            S_FINISH:
            begin
                if (!ov_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register
    assign id_ext  = {8'b0, run_task_reg};
    assign pri_ext = {8'b0, run_pri_reg};
    assign rdy_ext = {5'b0, rdy_reg};
    assign wt_ext  = {5'b0, wt_reg};
    assign mv_ext  = {5'b0, moved_reg};

    always_comb
    begin
        ov_next    = ov_reg && out_stall;
        o_sts_next = o_sts_reg;
        o_rv_next  = o_rv_reg;
        o_id_next  = o_id_reg;
        o_pri_next = o_pri_reg;
        o_pre_next = o_pre_reg;
        o_rdy_next = o_rdy_reg;
        o_wt_next  = o_wt_reg;
        o_mv_next  = o_mv_reg;
        if (state_reg == S_FINISH && (!ov_reg || !out_stall))
        begin
            ov_next    = 1'b1;
            o_sts_next = sts_reg;
            o_rv_next  = run_v_reg;
            o_id_next  = run_v_reg ? id_ext[7:0] : 8'd0;
            o_pri_next = run_v_reg ? pri_ext[7:0] : 8'd0;
            o_pre_next = pre_reg;
            o_rdy_next = rdy_ext[4:0];
            o_wt_next  = wt_ext[4:0];
            o_mv_next  = mv_ext[4:0];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            rdv_reg    <= 1'b0;
            def_ev_reg <= '0;
            used_reg   <= '0;
            stamp_reg  <= '0;
            rdy_reg    <= '0;
            wt_reg     <= '0;
            run_v_reg  <= 1'b0;
            run_task_reg <= '0;
            run_pri_reg  <= '0;
            run_ev_reg   <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rdv_reg    <= rdv_next;
            def_ev_reg <= def_ev_next;
            used_reg   <= used_next;
            stamp_reg  <= stamp_next;
            rdy_reg    <= rdy_next;
            wt_reg     <= wt_next;
            run_v_reg  <= run_v_next;
            run_task_reg <= run_task_next;
            run_pri_reg  <= run_pri_next;
            run_ev_reg   <= run_ev_next;
            ov_reg     <= ov_next;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        rdi_reg       <= rdi_next;
        act_reg       <= act_next;
        id_reg        <= id_next;
        pri_reg       <= pri_next;
        ev_reg        <= ev_next;
        fnd_reg       <= fnd_next;
        fnd_idx_reg   <= fnd_idx_next;
        fnd_wait_reg  <= fnd_wait_next;
        fnd_task_reg  <= fnd_task_next;
        fnd_pri_reg   <= fnd_pri_next;
        free_reg      <= free_next;
        free_idx_reg  <= free_idx_next;
        best_reg      <= best_next;
        best_idx_reg  <= best_idx_next;
        best_task_reg <= best_task_next;
        best_pri_reg  <= best_pri_next;
        best_ev_reg   <= best_ev_next;
        best_key_reg  <= best_key_next;
        match_reg     <= match_next;
        base_reg      <= base_next;
        sts_reg       <= sts_next;
        pre_reg       <= pre_next;
        moved_reg     <= moved_next;
        o_sts_reg     <= o_sts_next;
        o_rv_reg      <= o_rv_next;
        o_id_reg      <= o_id_next;
        o_pri_reg     <= o_pri_next;
        o_pre_reg     <= o_pre_next;
        o_rdy_reg     <= o_rdy_next;
        o_wt_reg      <= o_wt_next;
        o_mv_reg      <= o_mv_next;
    end

    assign out_valid        = ov_reg;
    assign status           = o_sts_reg;
    assign running_valid    = o_rv_reg;
    assign running_id       = o_id_reg;
    assign running_priority = o_pri_reg;
    assign preempted        = o_pre_reg;
    assign ready_count      = o_rdy_reg;
    assign waiting_count    = o_wt_reg;
    assign moved_count      = o_mv_reg;

`ifndef SYNTH
    // set sizes always agree with slot occupancy
    assert property (@(posedge clk) disable iff (!rst_n)
        (32'(rdy_reg) + 32'(wt_reg)) == 32'($countones(used_reg)))
        else $error("set counts disagree with occupied slots");

    // table writes happen only while deciding or releasing
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_EXEC || state_reg == S_TRIG))
        else $error("table written outside a write phase");

    // stamp counter never wraps or goes back
    assert property (@(posedge clk) disable iff (!rst_n)
        stamp_reg >= $past(stamp_reg))
        else $error("stamp counter went backwards");

    // a new transaction is taken only from idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_SCAN))
        else $error("accepted transaction did not start a scan");
`endif

endmodule
